// ===== rtl/sgs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgs_pkg - shared definitions for the Savitzky-Golay smoother
// Default sizes, register reset values, register index codes and the
// coefficient set selector used by the tap cells and the top level.
// ----------------------------------------------------------------------------
package sgs_pkg;

   // Default sizes handed to the top level parameters
   localparam int DEF_MAX_HALF_WIDTH = 12;
   localparam int DEF_SAMPLE_BITS    = 32;
   localparam int DEF_COEF_FRAC_BITS = 16;

   // Samples-seen counter, saturating
   localparam int                 COUNT_W   = 17;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Configuration port
   localparam int                 CFG_W         = 8;
   localparam int                 DEGREE_W      = 3;
   localparam int                 CSR_INDEX_W   = 1;
   localparam logic [CFG_W-1:0]   POINTS_RESET  = 8'd5;
   localparam logic [DEGREE_W-1:0] DEGREE_RESET = 3'd2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WINDOW_POINTS = 1'b0,
      CSR_POLY_DEGREE   = 1'b1
   } csr_index_type;

   // Coefficient families: degrees 0-1, 2-3 and 4-7
   localparam int NUM_COEF_SETS = 3;

   typedef enum logic [1:0] {
      SET_FLAT,
      SET_QUAD,
      SET_QUART
   } coef_set_type;

endpackage

// ===== rtl/sgs_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgs_if - item channels of the Savitzky-Golay smoother
// Valid/ready channels for the sample stream in and the smoothed stream out.
// ----------------------------------------------------------------------------
interface sgs_req_if #(
   parameter int DATA_W = sgs_pkg::DEF_SAMPLE_BITS
);
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] sample;
   logic                     last_sample;

   modport source (output valid, sample, last_sample, input ready);
   modport sink   (input valid, sample, last_sample, output ready);
endinterface

interface sgs_rsp_if #(
   parameter int DATA_W = sgs_pkg::DEF_SAMPLE_BITS
);
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] smoothed;
   logic                     last_out;

   modport source (output valid, smoothed, last_out, input ready);
   modport sink   (input valid, smoothed, last_out, output ready);
endinterface

// ===== rtl/sgs_tap_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgs_tap_cell - one tap of the smoothing window
// Holds one delay-line sample, passes it to the next cell on each accepted
// item and registers the product of the incoming sample with its weight.
// ----------------------------------------------------------------------------
module sgs_tap_cell #(
   parameter int  TAP            = 0,
   parameter int  MAX_HALF_WIDTH = sgs_pkg::DEF_MAX_HALF_WIDTH,
   parameter int  SAMPLE_BITS    = sgs_pkg::DEF_SAMPLE_BITS,
   parameter int  COEF_FRAC_BITS = sgs_pkg::DEF_COEF_FRAC_BITS,
   localparam int HW_W           = $clog2(MAX_HALF_WIDTH + 1),
   localparam int COEF_W         = COEF_FRAC_BITS + 2,
   localparam int PROD_W         = SAMPLE_BITS + COEF_W
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      shift_en,
   input  logic                      clear,
   input  logic                      load_en,
   input  logic [HW_W-1:0]           half_width,
   input  sgs_pkg::coef_set_type     coef_set,
   input  logic signed [SAMPLE_BITS-1:0] x_in,
   output logic signed [SAMPLE_BITS-1:0] x_out,
   output logic signed [PROD_W-1:0]  prod_out
);

   logic signed [COEF_W-1:0]      coef_rom [MAX_HALF_WIDTH+1][sgs_pkg::NUM_COEF_SETS];
   logic signed [COEF_W-1:0]      coef;
   logic signed [SAMPLE_BITS-1:0] delay_ff;
   logic signed [SAMPLE_BITS-1:0] delay_in;
   logic signed [PROD_W-1:0]      prod_ff;
   logic signed [PROD_W-1:0]      prod_in;

   // Weight table for this tap position, one entry per half-width and set.
   // Half-width zero never occurs after clamping.
   for (genvar s = 0; s < sgs_pkg::NUM_COEF_SETS; s++) begin : g_unused
      assign coef_rom[0][s] = '0;
   end

   for (genvar mi = 1; mi <= MAX_HALF_WIDTH; mi++) begin : g_hw
      for (genvar s = 0; s < sgs_pkg::NUM_COEF_SETS; s++) begin : g_set
         localparam longint MM = longint'(mi);
         localparam longint II = longint'((TAP - mi) * (TAP - mi));
         localparam longint M2 = MM * MM;
         localparam longint NUM_RAW =
            (s == int'(sgs_pkg::SET_FLAT)) ? 64'sd1 :
            (s == int'(sgs_pkg::SET_QUAD)) ? 3 * (3 * MM * (MM + 1) - 1 - 5 * II) :
            15 * ((15 * M2 * M2 + 30 * M2 * MM - 35 * M2 - 50 * MM + 12)
                  - 35 * (2 * M2 + 2 * MM - 3) * II + 63 * II * II);
         localparam longint DEN_RAW =
            (s == int'(sgs_pkg::SET_FLAT)) ? 2 * MM + 1 :
            (s == int'(sgs_pkg::SET_QUAD)) ? (4 * M2 - 1) * (2 * MM + 3) :
            4 * (4 * M2 - 1) * (4 * M2 - 9) * (2 * MM + 5);
         localparam longint NUM = (DEN_RAW < 0) ? -NUM_RAW : NUM_RAW;
         localparam longint DEN = (DEN_RAW < 0) ? -DEN_RAW : DEN_RAW;
         localparam longint SC  = NUM * (longint'(1) <<< COEF_FRAC_BITS);
         // rounded half away from zero
         localparam longint CQ  = (SC >= 0) ? (SC + DEN / 2) / DEN
                                            : -((-SC + DEN / 2) / DEN);
         localparam longint CW  = (TAP > 2 * mi) ? 64'sd0 : CQ;
         assign coef_rom[mi][s] = COEF_W'(CW);
      end
   end

   assign coef = coef_rom[half_width][coef_set];

   // Delay-line stage
   assign delay_in = clear ? '0 : x_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= '0;
      end else if (shift_en) begin
         delay_ff <= delay_in;
      end
   end

   // Weighted tap, registered
   assign prod_in = x_in * coef;

   always_ff @(posedge clock) begin
      if (load_en) begin
         prod_ff <= prod_in;
      end
   end

   assign x_out    = delay_ff;
   assign prod_out = prod_ff;

endmodule

// ===== rtl/sgs_adder_tree.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgs_adder_tree - registered pairwise sum of the tap products
// One register level per halving; the whole tree stalls with enable.
// ----------------------------------------------------------------------------
module sgs_adder_tree #(
   parameter int  NUM_IN = 2 * sgs_pkg::DEF_MAX_HALF_WIDTH + 1,
   parameter int  IN_W   = sgs_pkg::DEF_SAMPLE_BITS + sgs_pkg::DEF_COEF_FRAC_BITS + 2,
   localparam int LEVELS = $clog2(NUM_IN),
   localparam int SUM_W  = IN_W + LEVELS
) (
   input  logic                    clock,
   input  logic                    enable,
   input  logic signed [IN_W-1:0]  leaf [NUM_IN],
   output logic signed [SUM_W-1:0] sum
);

   logic signed [SUM_W-1:0] node0   [NUM_IN];
   logic signed [SUM_W-1:0] node_ff [1:LEVELS][NUM_IN];

   // Sign-extended leaves
   for (genvar k = 0; k < NUM_IN; k++) begin : g_leaf
      assign node0[k] = SUM_W'(leaf[k]);
   end

   // Each level adds neighbouring pairs of the level below
   for (genvar l = 1; l <= LEVELS; l++) begin : g_level
      localparam int PREV_N = (NUM_IN + (1 << (l - 1)) - 1) >> (l - 1);
      for (genvar k = 0; k < NUM_IN; k++) begin : g_node
         logic signed [SUM_W-1:0] node_in;
         if (2 * k + 1 < PREV_N) begin : g_pair
            if (l == 1) begin : g_first
               assign node_in = node0[2*k] + node0[2*k+1];
            end else begin : g_upper
               assign node_in = node_ff[l-1][2*k] + node_ff[l-1][2*k+1];
            end
         end else if (2 * k < PREV_N) begin : g_odd
            if (l == 1) begin : g_first
               assign node_in = node0[2*k];
            end else begin : g_upper
               assign node_in = node_ff[l-1][2*k];
            end
         end else begin : g_none
            assign node_in = '0;
         end

         always_ff @(posedge clock) begin
            if (enable) begin
               node_ff[l][k] <= node_in;
            end
         end
      end
   end

   assign sum = node_ff[LEVELS][0];

endmodule

// ===== rtl/savitzky_golay_smoother.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// savitzky_golay_smoother - streaming Savitzky-Golay smoothing filter
// Symmetric window of up to 2*MAX_HALF_WIDTH+1 taps in a row of cells,
// registered adder tree, rounding and saturation, and an output sequencer
// that emits the zero edge results of each curve.
// ----------------------------------------------------------------------------
// One sample is taken per clock while the result side keeps up; each result
// passes through the adder tree levels, the rounding stage and the output
// register after the edge that takes the sample completing its window; the tap
// products are registered on the accepting edge itself. The sample flagged
// last_sample is followed by its trailing zero results, as many as the half-width
// (fewer on a short curve), one per cycle while the output is taken, and the
// input stays closed until they are all sent (at most MAX_HALF_WIDTH).
// Half-width and degree come from the two configuration registers and should
// only be changed while the block is idle.
// ----------------------------------------------------------------------------
module savitzky_golay_smoother #(
   parameter int MAX_HALF_WIDTH = sgs_pkg::DEF_MAX_HALF_WIDTH,
   parameter int SAMPLE_BITS    = sgs_pkg::DEF_SAMPLE_BITS,
   parameter int COEF_FRAC_BITS = sgs_pkg::DEF_COEF_FRAC_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [sgs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sgs_pkg::CFG_W-1:0]       csr_data,
   sgs_req_if.sink                         req_chan,
   sgs_rsp_if.source                       rsp_chan
);

   localparam int TAPS   = 2 * MAX_HALF_WIDTH + 1;
   localparam int HW_W   = $clog2(MAX_HALF_WIDTH + 1);
   localparam int COEF_W = COEF_FRAC_BITS + 2;
   localparam int PROD_W = SAMPLE_BITS + COEF_W;
   localparam int LEVELS = $clog2(TAPS);
   localparam int SUM_W  = PROD_W + LEVELS;
   localparam int SUM_X  = SUM_W + 1;
   localparam int DEPTH  = LEVELS + 2;

   localparam logic signed [SUM_X-1:0] ROUND_BIAS = SUM_X'(1) << (COEF_FRAC_BITS - 1);
   localparam logic signed [SUM_X-1:0] SAT_HI =
      {{(SUM_X - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
   localparam logic signed [SUM_X-1:0] SAT_LO = ~SAT_HI;

   // Per-item control travelling alongside the data
   typedef struct packed {
      logic            valid;
      logic            has_main;
      logic            filtered;
      logic            last;
      logic [HW_W-1:0] zeros;
   } ctl_type;

   logic [sgs_pkg::CFG_W-1:0]    window_points_ff;
   logic [sgs_pkg::DEGREE_W-1:0] poly_degree_ff;
   logic [sgs_pkg::CFG_W-2:0]    points_half;
   logic [HW_W-1:0]              half_width;
   sgs_pkg::coef_set_type        coef_set;

   logic [sgs_pkg::COUNT_W-1:0]  count_ff;
   logic [sgs_pkg::COUNT_W-1:0]  count_in;
   logic                         accept;
   logic                         adv;
   logic                         out_free;
   ctl_type                      desc;
   ctl_type                      ctl_ff [DEPTH];
   ctl_type                      fin;

   logic signed [SAMPLE_BITS-1:0] tap_x    [TAPS];
   logic signed [PROD_W-1:0]      tap_prod [TAPS];
   logic signed [SUM_W-1:0]       tree_sum;
   logic signed [SUM_X-1:0]       biased;
   logic signed [SUM_X-1:0]       scaled;
   logic signed [SAMPLE_BITS-1:0] res_ff;
   logic signed [SAMPLE_BITS-1:0] res_in;

   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_data_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_data_in;
   logic                          rsp_last_ff;
   logic                          rsp_last_in;
   logic [HW_W-1:0]               pend_ff;
   logic [HW_W-1:0]               pend_in;
   logic                          pend_last_ff;
   logic                          pend_last_in;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         window_points_ff <= sgs_pkg::POINTS_RESET;
         poly_degree_ff   <= sgs_pkg::DEGREE_RESET;
      end else if (csr_we) begin
         case (sgs_pkg::csr_index_type'(csr_index))
            sgs_pkg::CSR_WINDOW_POINTS: window_points_ff <= csr_data;
            sgs_pkg::CSR_POLY_DEGREE:   poly_degree_ff   <= csr_data[sgs_pkg::DEGREE_W-1:0];
            default: ;
         endcase
      end
   end

   // Half-width clamp and coefficient family
   assign points_half = window_points_ff[sgs_pkg::CFG_W-1:1];

   always_comb begin
      if (points_half == '0) begin
         half_width = HW_W'(1);
      end else if (points_half > MAX_HALF_WIDTH) begin
         half_width = HW_W'(MAX_HALF_WIDTH);
      end else begin
         half_width = HW_W'(points_half);
      end
      case (poly_degree_ff) inside
         [3'd0:3'd1]: coef_set = sgs_pkg::SET_FLAT;
         [3'd2:3'd3]: coef_set = sgs_pkg::SET_QUAD;
         default:     coef_set = sgs_pkg::SET_QUART;
      endcase
   end

   // Handshake: the pipeline moves when the output slot frees and no tail is due
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign adv            = out_free && (pend_ff == '0);
   assign req_chan.ready = adv;
   assign accept         = req_chan.valid && adv;

   // Item descriptor from the sample count
   always_comb begin
      desc          = '0;
      desc.valid    = 1'b1;
      desc.has_main = count_ff >= sgs_pkg::COUNT_W'(half_width);
      desc.filtered = count_ff >= (sgs_pkg::COUNT_W'(half_width) << 1);
      desc.last     = req_chan.last_sample;
      if (req_chan.last_sample) begin
         desc.zeros = desc.has_main ? half_width : HW_W'(count_ff) + HW_W'(1);
      end
      if (req_chan.last_sample) begin
         count_in = '0;
      end else if (count_ff != sgs_pkg::COUNT_MAX) begin
         count_in = count_ff + 1'b1;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         count_ff <= count_in;
      end
   end

   // Control pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            ctl_ff[i] <= '0;
         end
      end else if (adv) begin
         ctl_ff[0] <= accept ? desc : '0;
         for (int i = 1; i < DEPTH; i++) begin
            ctl_ff[i] <= ctl_ff[i-1];
         end
      end
   end

   assign fin = ctl_ff[DEPTH-1];

   // Row of tap cells; cell 0 takes the new sample
   for (genvar t = 0; t < TAPS; t++) begin : g_tap
      logic signed [SAMPLE_BITS-1:0] cell_x_in;
      if (t == 0) begin : g_head
         assign cell_x_in = req_chan.sample;
      end else begin : g_body
         assign cell_x_in = tap_x[t-1];
      end

      sgs_tap_cell #(
         .TAP            (t),
         .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
         .SAMPLE_BITS    (SAMPLE_BITS),
         .COEF_FRAC_BITS (COEF_FRAC_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift_en   (accept),
         .clear      (req_chan.last_sample),
         .load_en    (adv),
         .half_width (half_width),
         .coef_set   (coef_set),
         .x_in       (cell_x_in),
         .x_out      (tap_x[t]),
         .prod_out   (tap_prod[t])
      );
   end

   sgs_adder_tree #(
      .NUM_IN (TAPS),
      .IN_W   (PROD_W)
   ) u_tree (
      .clock  (clock),
      .enable (adv),
      .leaf   (tap_prod),
      .sum    (tree_sum)
   );

   // Round half up, drop fraction bits, saturate
   assign biased = SUM_X'(tree_sum) + ROUND_BIAS;
   assign scaled = biased >>> COEF_FRAC_BITS;

   always_comb begin
      if (scaled > SAT_HI) begin
         res_in = SAMPLE_BITS'(SAT_HI);
      end else if (scaled < SAT_LO) begin
         res_in = SAMPLE_BITS'(SAT_LO);
      end else begin
         res_in = scaled[SAMPLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         res_ff <= res_in;
      end
   end

   // Output sequencer: main result first, then the trailing zeros of a curve
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      pend_in      = pend_ff;
      pend_last_in = pend_last_ff;
      if (out_free) begin
         if (pend_ff != '0) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = '0;
            rsp_last_in  = (pend_ff == HW_W'(1)) && pend_last_ff;
            pend_in      = pend_ff - HW_W'(1);
         end else if (fin.valid && fin.has_main) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = fin.filtered ? res_ff : '0;
            rsp_last_in  = 1'b0;
            pend_in      = fin.zeros;
            pend_last_in = fin.last;
         end else if (fin.valid && (fin.zeros != '0)) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = '0;
            rsp_last_in  = fin.zeros == HW_W'(1);
            pend_in      = fin.zeros - HW_W'(1);
            pend_last_in = fin.last;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pend_ff      <= '0;
         pend_last_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         pend_last_ff <= pend_last_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.smoothed = rsp_data_ff;
   assign rsp_chan.last_out = rsp_last_ff;

   // Checks
   a_tail_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (pend_ff != '0) |-> !req_chan.ready)
      else $error("input open while trailing zeros are due");

   a_tail_needs_output: assert property (@(posedge clock) disable iff (reset)
      (pend_ff != '0) |-> rsp_valid_ff)
      else $error("trailing zeros due with empty output register");

   a_last_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_data_ff == '0))
      else $error("final item of a curve is not zero");

   a_count_clears: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.last_sample) |=> (count_ff == '0))
      else $error("sample count not cleared after last sample");

endmodule
